// ===== rtl/grp_pkg.sv =====
// Shared types and constants for the guillotine rectangle packer.
// No dependencies.
package grp_pkg;
  localparam int unsigned DimW = 15;
  localparam int unsigned PosW = 14;
  localparam int unsigned PadW = 8;
  localparam int unsigned AreaW = 30;
  localparam logic [DimW-1:0] AreaLimit = 15'd16384;

  localparam logic [1:0] CfgAreaW = 2'd0;
  localparam logic [1:0] CfgAreaH = 2'd1;
  localparam logic [1:0] CfgPadX  = 2'd2;
  localparam logic [1:0] CfgPadY  = 2'd3;

  localparam logic OpPlace   = 1'b0;
  localparam logic OpRestart = 1'b1;

  typedef struct packed {
    logic [DimW-1:0] x;
    logic [DimW-1:0] y;
    logic [DimW-1:0] w;
    logic [DimW-1:0] h;
  } rect_t;

  // A free list entry keeps its area so the insert search needs no multiply.
  typedef struct packed {
    rect_t            r;
    logic [AreaW-1:0] area;
  } entry_t;

  function automatic logic [DimW-1:0] clamp_area(input logic [DimW-1:0] v);
    clamp_area = (v > AreaLimit) ? AreaLimit : v;
  endfunction
endpackage

// ===== rtl/grp_mult.sv =====
// Registered 15x15 area multiplier shared by the sequencer.
// Depends on grp_pkg.
module grp_mult
  import grp_pkg::*;
(
  input  logic             clk,
  input  logic [DimW-1:0]  a,
  input  logic [DimW-1:0]  b,
  output logic [AreaW-1:0] p
);
  logic [AreaW-1:0] p_r;
  always_ff @(posedge clk) begin
    p_r <= AreaW'(a) * AreaW'(b);
  end
  assign p = p_r;
endmodule

// ===== rtl/guillotine_rect_packer.sv =====
// Top level of the guillotine rectangle packer: sequencer, free list memory
// and result register. Depends on grp_pkg and grp_mult.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid in_stall in_*         | in
//  result  | out_valid out_stall out_*      | out
//  config  | cfg_we cfg_index cfg_data      | in
//
// One word per item. A restart goes from the idle state straight to the done
// state and from there into the output register. A placement seeds the list
// with the whole area when it is the first since reset or restart, scans the
// entries from the last down to the first until one fits, removes the hit by
// moving each entry above it down one place, inserts each remainder in area
// order after moving the entries from its place up, and then loads the result.
// The memory needs no clearing after reset. Input stall is high
// while the sequencer is busy; a waiting result holds only the last step.
module guillotine_rect_packer
  import grp_pkg::*;
#(
  parameter int unsigned MAX_FREE = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_operation,
  input  logic [DimW-1:0]  in_rect_w,
  input  logic [DimW-1:0]  in_rect_h,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_placed,
  output logic [PosW-1:0]  out_pos_x,
  output logic [PosW-1:0]  out_pos_y,
  output logic [DimW-1:0]  out_used_w,
  output logic [DimW-1:0]  out_used_h,
  output logic             out_remainder_lost,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DimW-1:0]  cfg_data
);
  localparam int unsigned IdxW = $clog2(MAX_FREE);
  localparam int unsigned CntW = $clog2(MAX_FREE + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FREE);
  localparam logic [CntW-1:0] One = CntW'(1);
  localparam logic [CntW-1:0] Two = CntW'(2);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_SEED   = 13'b0000000000010,
    S_SEEDW  = 13'b0000000000100,
    S_SREAD  = 13'b0000000001000,
    S_SCHK   = 13'b0000000010000,
    S_RMRD   = 13'b0000000100000,
    S_RMWR   = 13'b0000001000000,
    S_INS    = 13'b0000010000000,
    S_IAREA  = 13'b0000100000000,
    S_ICMP   = 13'b0001000000000,
    S_IMOV   = 13'b0010000000000,
    S_IWR    = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [DimW-1:0] area_w_r, area_h_r;
  logic [PadW-1:0] pad_x_r, pad_y_r;
  logic [CntW-1:0] cnt_r;
  logic            fresh_r;
  logic [DimW-1:0] ext_x_r, ext_y_r;

  logic [DimW-1:0] rw_r, rh_r;
  logic [DimW:0]   pw_r, ph_r;
  logic [CntW-1:0] i_r;       // scan / shift index
  logic [CntW-1:0] pos_r;     // insert position
  entry_t          rd_r;      // registered memory read
  rect_t           small_r, cur_r;
  logic            second_r;  // inserting the small remainder
  logic [AreaW-1:0] cur_area_r;
  logic            placed_r, lost_r;
  logic [DimW-1:0] px_r, py_r;
  logic            ovalid_r;

  logic            oplaced_r, olost_r;
  logic [PosW-1:0] opx_r, opy_r;
  logic [DimW-1:0] oused_w_r, oused_h_r;

  entry_t mem [MAX_FREE];
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  logic [DimW-1:0] ma, mb;
  logic [AreaW-1:0] mp;
  grp_mult u_mult (.clk(clk), .a(ma), .b(mb), .p(mp));

  logic accept;
  logic load_out;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign load_out = (state_r == S_DONE) && (!ovalid_r || !out_stall);

  // Fit test and split of the entry just read.
  logic fits;
  logic [DimW:0] dw, dh;
  rect_t big_c, small_c;
  logic [DimW:0] ex_c, ey_c;
  always_comb begin
    fits = (pw_r <= {1'b0, rd_r.r.w}) && (ph_r <= {1'b0, rd_r.r.h});
    dw = {1'b0, rd_r.r.w} - pw_r;
    dh = {1'b0, rd_r.r.h} - ph_r;
    if (dw > dh) begin
      big_c   = '{x: rd_r.r.x + pw_r[DimW-1:0], y: rd_r.r.y, w: dw[DimW-1:0],
                  h: rd_r.r.h};
      small_c = '{x: rd_r.r.x, y: rd_r.r.y + ph_r[DimW-1:0], w: pw_r[DimW-1:0],
                  h: dh[DimW-1:0]};
    end else begin
      big_c   = '{x: rd_r.r.x, y: rd_r.r.y + ph_r[DimW-1:0], w: rd_r.r.w,
                  h: dh[DimW-1:0]};
      small_c = '{x: rd_r.r.x + pw_r[DimW-1:0], y: rd_r.r.y, w: dw[DimW-1:0],
                  h: ph_r[DimW-1:0]};
    end
    ex_c = {1'b0, rd_r.r.x} + {1'b0, rw_r};
    ey_c = {1'b0, rd_r.r.y} + {1'b0, rh_r};
  end

  logic keep;
  assign keep = (cur_r.w >= DimW'(pad_x_r)) && (cur_r.h >= DimW'(pad_y_r));

  always_comb begin
    state_nxt = state_r;
    we    = 1'b0;
    waddr = i_r[IdxW-1:0];
    wdata = rd_r;
    raddr = i_r[IdxW-1:0];
    ma    = cur_r.w;
    mb    = cur_r.h;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OpRestart) state_nxt = S_DONE;
          else if (fresh_r) state_nxt = S_SEED;
          else state_nxt = S_SREAD;
        end
      end
      S_SEED: begin
        ma = clamp_area(area_w_r);
        mb = clamp_area(area_h_r);
        state_nxt = S_SEEDW;
      end
      S_SEEDW: begin
        we = 1'b1;
        waddr = '0;
        wdata.r.x = '0;
        wdata.r.y = '0;
        wdata.r.w = clamp_area(area_w_r);
        wdata.r.h = clamp_area(area_h_r);
        wdata.area = mp;
        state_nxt = S_SREAD;
      end
      S_SREAD: begin
        raddr = IdxW'(i_r - One);
        state_nxt = (i_r == '0) ? S_DONE : S_SCHK;
      end
      S_SCHK: begin
        state_nxt = fits ? S_RMRD : S_SREAD;
      end
      S_RMRD: begin
        raddr = IdxW'(i_r + One);
        state_nxt = (i_r + One >= cnt_r) ? S_INS : S_RMWR;
      end
      S_RMWR: begin
        we = 1'b1;
        waddr = i_r[IdxW-1:0];
        wdata = rd_r;
        raddr = IdxW'(i_r + Two);
        state_nxt = (i_r + Two >= cnt_r) ? S_INS : S_RMWR;
      end
      S_INS: begin
        if (!keep || cnt_r >= MaxCnt) state_nxt = second_r ? S_DONE : S_INS;
        else state_nxt = S_IAREA;
      end
      S_IAREA: begin
        raddr = '0;
        state_nxt = (cnt_r == '0) ? S_IWR : S_ICMP;
      end
      S_ICMP: begin
        if (rd_r.area > cur_area_r && i_r + One < cnt_r) begin
          raddr = IdxW'(i_r + One);
          state_nxt = S_ICMP;
        end else if (rd_r.area > cur_area_r) begin
          state_nxt = S_IWR;
        end else begin
          raddr = IdxW'(cnt_r - One);
          state_nxt = S_IMOV;
        end
      end
      S_IMOV: begin
        // Entries move up one place, from the top down to the insert position.
        we = 1'b1;
        waddr = i_r[IdxW-1:0];
        wdata = rd_r;
        raddr = IdxW'(i_r - Two);
        state_nxt = (i_r - One > pos_r) ? S_IMOV : S_IWR;
      end
      S_IWR: begin
        we = 1'b1;
        waddr = pos_r[IdxW-1:0];
        wdata.r = cur_r;
        wdata.area = cur_area_r;
        state_nxt = second_r ? S_DONE : S_INS;
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      area_w_r <= 15'd1024;
      area_h_r <= 15'd1024;
      pad_x_r  <= '0;
      pad_y_r  <= '0;
      cnt_r    <= '0;
      fresh_r  <= 1'b1;
      ext_x_r  <= '0;
      ext_y_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= load_out || (ovalid_r && out_stall);
      if (cfg_we) begin
        case (cfg_index)
          CfgAreaW: area_w_r <= cfg_data;
          CfgAreaH: area_h_r <= cfg_data;
          CfgPadX:  pad_x_r  <= cfg_data[PadW-1:0];
          CfgPadY:  pad_y_r  <= cfg_data[PadW-1:0];
          default:  ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            rw_r <= in_rect_w;
            rh_r <= in_rect_h;
            pw_r <= {1'b0, in_rect_w} + (DimW+1)'(pad_x_r);
            ph_r <= {1'b0, in_rect_h} + (DimW+1)'(pad_y_r);
            placed_r <= 1'b0;
            lost_r   <= 1'b0;
            px_r <= '0;
            py_r <= '0;
            second_r <= 1'b0;
            i_r <= cnt_r;
            if (in_operation == OpRestart) begin
              cnt_r   <= '0;
              fresh_r <= 1'b1;
              ext_x_r <= '0;
              ext_y_r <= '0;
            end
          end
        end
        S_SEEDW: begin
          // The scan then reads the seeded whole area back.
          fresh_r <= 1'b0;
          cnt_r   <= One;
          i_r     <= One;
        end
        S_SREAD: begin
          if (i_r != '0) i_r <= i_r - One;
        end
        S_SCHK: begin
          if (fits) begin
            placed_r <= 1'b1;
            px_r <= rd_r.r.x;
            py_r <= rd_r.r.y;
            if (ex_c > {1'b0, ext_x_r}) ext_x_r <= ex_c[DimW-1:0];
            if (ey_c > {1'b0, ext_y_r}) ext_y_r <= ey_c[DimW-1:0];
            small_r <= small_c;
            cur_r   <= big_c;
          end
        end
        S_RMRD: begin
          if (state_nxt == S_INS) cnt_r <= cnt_r - One;
        end
        S_RMWR: begin
          i_r <= i_r + One;
          if (state_nxt == S_INS) cnt_r <= cnt_r - One;
        end
        S_INS: begin
          if (!keep || cnt_r >= MaxCnt) begin
            if (keep) lost_r <= 1'b1;
            if (!second_r) begin
              second_r <= 1'b1;
              cur_r <= small_r;
            end
          end
        end
        S_IAREA: begin
          cur_area_r <= mp;
          i_r   <= '0;
          pos_r <= '0;
        end
        S_ICMP: begin
          if (state_nxt == S_ICMP) begin
            i_r <= i_r + One;
          end else if (state_nxt == S_IWR) begin
            pos_r <= cnt_r;
          end else begin
            pos_r <= i_r;
            i_r   <= cnt_r;
          end
        end
        S_IMOV: begin
          i_r <= i_r - One;
        end
        S_IWR: begin
          cnt_r <= cnt_r + One;
          if (!second_r) begin
            second_r <= 1'b1;
            cur_r <= small_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded when the previous word has left.
  always_ff @(posedge clk) begin
    if (load_out) begin
      oplaced_r <= placed_r;
      opx_r     <= px_r[PosW-1:0];
      opy_r     <= py_r[PosW-1:0];
      oused_w_r <= ext_x_r;
      oused_h_r <= ext_y_r;
      olost_r   <= lost_r;
    end
  end

  assign out_valid          = ovalid_r;
  assign out_placed         = oplaced_r;
  assign out_pos_x          = opx_r;
  assign out_pos_y          = opy_r;
  assign out_used_w         = oused_w_r;
  assign out_used_h         = oused_h_r;
  assign out_remainder_lost = olost_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r));
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MaxCnt);
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable({out_placed, out_pos_x, out_pos_y,
                                                     out_used_w, out_used_h,
                                                     out_remainder_lost}));
endmodule
